// ===== src/msqm_pkg.sv =====
`default_nettype none

package msqm_pkg;

    // sizes
    localparam int NUM_LISTS  = 16;
    localparam int POOL_DEPTH = 256;

    localparam int LIST_W = $clog2(NUM_LISTS);
    localparam int SLOT_W = $clog2(POOL_DEPTH);
    localparam int CNT_W  = $clog2(POOL_DEPTH + 1);

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int ID_W     = 4;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;

    // pool word: value above, link below
    localparam int POOL_W = DATA_W + SLOT_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_CREATE = 2'd0,
        REQ_PUSH   = 2'd1,
        REQ_POP    = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EXISTS  = 3'd1,
        ST_MISSING = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_LINK = 2'd2
    } t_fsm;

endpackage

`default_nettype wire

// ===== src/multi_stack_queue_manager.sv =====
`default_nettype none
// o_valid marks the result word in the cycle after the exec cycle
// a new request is taken only while idle, not during the exec cycle; a push onto a non-empty queue
//   also needs a link state, which writes the old tail's link through the single pool write port
// reset: synchronous active-low i_rst_n clears every list, the free count and the
//   allocation watermark; no clearing pass, the block is ready the cycle after reset
// the receiver cannot stall: o_valid is high for exactly one cycle per result
module multi_stack_queue_manager (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [msqm_pkg::REQ_W-1:0]            i_req_type,
    input  wire logic [msqm_pkg::ID_W-1:0]             i_list_id,
    input  wire logic                                  i_list_kind,
    input  wire logic signed [msqm_pkg::DATA_W-1:0]    i_push_data,
    output logic                                       o_valid,
    output logic [msqm_pkg::STATUS_W-1:0]              o_status,
    output logic                                       o_has_value,
    output logic signed [msqm_pkg::DATA_W-1:0]         o_popped_data
);

    localparam int LIST_W = msqm_pkg::LIST_W;
    localparam int SLOT_W = msqm_pkg::SLOT_W;
    localparam int CNT_W  = msqm_pkg::CNT_W;
    localparam int DATA_W = msqm_pkg::DATA_W;
    localparam int POOL_W = msqm_pkg::POOL_W;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    msqm_pkg::t_fsm r_state, n_state;

    // request latched at accept
    logic [msqm_pkg::REQ_W-1:0] r_req;
    logic [msqm_pkg::ID_W-1:0]  r_id;
    logic                       r_kind;
    logic [DATA_W-1:0]          r_data;

    // pool memory {value, link} and free slot stack memory
    logic [POOL_W-1:0] r_pool [msqm_pkg::POOL_DEPTH];
    logic [SLOT_W-1:0] r_free [msqm_pkg::POOL_DEPTH];
    logic [POOL_W-1:0] r_pool_rd;
    logic [SLOT_W-1:0] r_free_rd;

    // free stack depth and lowest depth ever reached; stack positions at or
    // above the watermark have been written, those below still hold their index
    logic [CNT_W-1:0] r_free_cnt;
    logic [CNT_W-1:0] r_low;

    // per-list table
    logic [SLOT_W-1:0]          r_first [msqm_pkg::NUM_LISTS];
    logic [SLOT_W-1:0]          r_last  [msqm_pkg::NUM_LISTS];
    logic [CNT_W-1:0]           r_count [msqm_pkg::NUM_LISTS];
    logic [msqm_pkg::NUM_LISTS-1:0] r_exists;
    logic [msqm_pkg::NUM_LISTS-1:0] r_queue;

    // pending tail link for a queue push
    logic [SLOT_W-1:0] r_link_addr;
    logic [SLOT_W-1:0] r_link_slot;

    // result word
    logic                          r_valid;
    logic [msqm_pkg::STATUS_W-1:0] r_status;
    logic                          r_has_value;
    logic [DATA_W-1:0]             r_popped;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    logic w_accept;
    logic w_exec;
    logic w_link;
    logic w_need_link;

    always_comb begin
        case (r_state)
            msqm_pkg::FSM_IDLE: n_state = w_accept ? msqm_pkg::FSM_EXEC : msqm_pkg::FSM_IDLE;
            msqm_pkg::FSM_EXEC: n_state = w_need_link ? msqm_pkg::FSM_LINK : msqm_pkg::FSM_IDLE;
            msqm_pkg::FSM_LINK: n_state = msqm_pkg::FSM_IDLE;
            default:            n_state = msqm_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        busy   = 1'b1;
        w_exec = 1'b0;
        w_link = 1'b0;
        case (r_state)
            msqm_pkg::FSM_IDLE: busy = 1'b0;
            msqm_pkg::FSM_EXEC: w_exec = 1'b1;
            msqm_pkg::FSM_LINK: w_link = 1'b1;
            default:            busy = 1'b1;
        endcase
    end

    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msqm_pkg::FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // decode of the latched request (used in the exec cycle)
    // ------------------------------------------------------------------
    logic [LIST_W-1:0] w_id;
    logic              w_id_bad;
    logic [CNT_W-1:0]  w_cnt;
    logic              w_empty;
    logic [CNT_W-1:0]  w_top;      // free stack position taken by a push
    logic [SLOT_W-1:0] w_slot;     // slot handed out by a push
    logic [SLOT_W-1:0] w_head;
    logic              w_do_create;
    logic              w_do_push;
    logic              w_do_pop;
    logic [msqm_pkg::STATUS_W-1:0] w_status;

    assign w_id     = r_id[LIST_W-1:0];
    assign w_id_bad = 32'(r_id) >= msqm_pkg::NUM_LISTS;
    assign w_cnt    = r_count[w_id];
    assign w_empty  = (w_cnt == '0);
    assign w_top    = r_free_cnt - CNT_W'(1);
    // never-written stack position still holds its own index
    assign w_slot   = (w_top < r_low) ? w_top[SLOT_W-1:0] : r_free_rd;
    assign w_head   = r_first[w_id];

    always_comb begin
        w_do_create = 1'b0;
        w_do_push   = 1'b0;
        w_do_pop    = 1'b0;
        w_status    = msqm_pkg::ST_OK;
        if (w_id_bad) begin
            w_status = msqm_pkg::ST_MISSING;
        end else if (r_req == msqm_pkg::REQ_CREATE) begin
            if (r_exists[w_id]) begin
                w_status = msqm_pkg::ST_EXISTS;
            end else begin
                w_do_create = w_exec;
            end
        end else if (!r_exists[w_id]) begin
            w_status = msqm_pkg::ST_MISSING;
        end else if (r_req == msqm_pkg::REQ_PUSH) begin
            if (r_free_cnt == '0) begin
                w_status = msqm_pkg::ST_FULL;
            end else begin
                w_do_push = w_exec;
            end
        end else begin
            // unused request code decodes as pop
            if (w_empty) begin
                w_status = msqm_pkg::ST_EMPTY;
            end else begin
                w_do_pop = w_exec;
            end
        end
        w_need_link = w_do_push && !w_empty && r_queue[w_id];
    end

    // ------------------------------------------------------------------
    // request latch
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_req_type;
            r_id   <= i_list_id;
            r_kind <= i_list_kind;
            r_data <= i_push_data;
        end
    end

    // ------------------------------------------------------------------
    // pool memory: read head at accept, write new entry or tail link later
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pool_rd <= r_pool[r_first[i_list_id[LIST_W-1:0]]];
        end
        if (w_do_push) begin
            // stack push links to the old head; for a queue the link is rewritten later
            r_pool[w_slot] <= {r_data, w_head};
        end else if (w_link) begin
            r_pool[r_link_addr][SLOT_W-1:0] <= r_link_slot;
        end
    end

    // ------------------------------------------------------------------
    // free slot stack memory
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_free_rd <= r_free[w_top[SLOT_W-1:0]];
        end
        if (w_do_pop && (r_free_cnt < CNT_W'(msqm_pkg::POOL_DEPTH))) begin
            r_free[r_free_cnt[SLOT_W-1:0]] <= w_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_cnt <= CNT_W'(msqm_pkg::POOL_DEPTH);
            r_low      <= CNT_W'(msqm_pkg::POOL_DEPTH);
        end else if (w_do_push) begin
            r_free_cnt <= w_top;
            if (w_top < r_low) begin
                r_low <= w_top;
            end
        end else if (w_do_pop && (r_free_cnt < CNT_W'(msqm_pkg::POOL_DEPTH))) begin
            r_free_cnt <= r_free_cnt + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // list table
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exists <= '0;
            r_queue  <= '0;
            for (int i = 0; i < msqm_pkg::NUM_LISTS; i++) begin
                r_count[i] <= '0;
            end
        end else if (w_do_create) begin
            r_exists[w_id] <= 1'b1;
            r_queue[w_id]  <= r_kind;
            r_count[w_id]  <= '0;
        end else if (w_do_push) begin
            if (w_cnt < CNT_W'(msqm_pkg::POOL_DEPTH)) begin
                r_count[w_id] <= w_cnt + CNT_W'(1);
            end
        end else if (w_do_pop) begin
            r_count[w_id] <= w_cnt - CNT_W'(1);
        end
    end

    // head and tail pointers, meaningful only while the list is non-empty
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            if (w_empty) begin
                r_first[w_id] <= w_slot;
                r_last[w_id]  <= w_slot;
            end else if (r_queue[w_id]) begin
                r_last[w_id] <= w_slot;
            end else begin
                r_first[w_id] <= w_slot;
            end
        end else if (w_do_pop) begin
            r_first[w_id] <= r_pool_rd[SLOT_W-1:0];
        end
        if (w_need_link) begin
            r_link_addr <= r_last[w_id];
            r_link_slot <= w_slot;
        end
    end

    // ------------------------------------------------------------------
    // result word
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status    <= w_status;
            r_has_value <= w_do_pop;
            r_popped    <= w_do_pop ? r_pool_rd[POOL_W-1:SLOT_W] : '0;
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_has_value   = r_has_value;
    assign o_popped_data = r_popped;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_cnt <= CNT_W'(msqm_pkg::POOL_DEPTH))
        else $error("free count above pool depth");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_free_cnt)
        else $error("watermark above free count");

    a_exec_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exec |=> o_valid)
        else $error("exec cycle without result strobe");

    a_link_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link |-> $past(w_need_link))
        else $error("tail link cycle without queue push");

    a_value_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_value) |-> (o_status == msqm_pkg::ST_OK))
        else $error("popped value with error status");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_value) |-> (o_popped_data == '0))
        else $error("nonzero data without value");

endmodule

`default_nettype wire
